// ----- design/plh_pkg.sv -----
`timescale 1ns / 1ps

package plh_pkg;

    localparam int BUCKETS_DEF = 32;
    localparam int ENTRIES_DEF = 64;

    localparam int FILE_W = 8;
    localparam int PAGE_W = 24;
    localparam int SLOT_W = 6;
    localparam int SUM_W  = PAGE_W + 1;

    typedef enum logic [1:0] {
        KIND_FIND   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EXISTS  = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [FILE_W-1:0]   file_number;
        logic [PAGE_W-1:0]   page_number;
        logic [SLOT_W-1:0]   buffer_slot;
    } t_in_beat;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   found_slot;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_FINISH,
        S_RESP
    } t_state;

endpackage

// ----- design/plh_hash.sv -----
`timescale 1ns / 1ps

module plh_hash import plh_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [FILE_W-1:0]                             i_file,
    input  logic [PAGE_W-1:0]                             i_page,
    output logic                                          o_done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);

    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int SH     = SUM_W + BW;
    localparam int REC_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + REC_W;
    localparam longint unsigned RECIP = (64'd1 << SH) / BUCKETS;
    localparam logic [REC_W-1:0] REC_C = REC_W'(RECIP);

    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_part;
    logic              r_phase;
    logic              r_busy;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  quot;
    logic [SUM_W-1:0]  qb;
    logic [BW-1:0]     rem;

    assign sum = SUM_W'(i_file) + SUM_W'(i_page);

    // quotient by reciprocal multiplication, low by at most one; fix with one subtract
    assign quot = SUM_W'(r_prod >> SH);
    assign qb   = SUM_W'(quot * SUM_W'(BUCKETS));
    assign rem  = (r_part >= SUM_W'(BUCKETS)) ? BW'(r_part - SUM_W'(BUCKETS)) : BW'(r_part);

    assign o_done   = !r_busy;
    assign o_bucket = POW2 ? (r_sum[BW-1:0] & BW'(BUCKETS - 1)) : rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= !POW2;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_busy  <= !r_phase;
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= sum;
        end
        if (r_busy && !r_phase) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(REC_C);
        end
        if (r_busy && r_phase) begin
            r_part <= r_sum - qb;
        end
    end

endmodule

// ----- design/plh_entry_mem.sv -----
`timescale 1ns / 1ps

module plh_entry_mem import plh_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                                               i_clk,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   i_rd_addr,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   i_wr_addr,
    input  logic                                               i_key_we,
    input  logic [FILE_W-1:0]                                  i_file,
    input  logic [PAGE_W-1:0]                                  i_page,
    input  logic [SLOT_W-1:0]                                  i_slot,
    input  logic                                               i_next_we,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0]     i_next,
    output logic [FILE_W-1:0]                                  o_file,
    output logic [PAGE_W-1:0]                                  o_page,
    output logic [SLOT_W-1:0]                                  o_slot,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0]     o_next
);

    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int REC_W = FILE_W + PAGE_W + SLOT_W;

    logic [REC_W-1:0] r_key_mem  [ENTRIES];
    logic [EW:0]      r_next_mem [ENTRIES];
    logic [REC_W-1:0] r_key_q;
    logic [EW:0]      r_next_q;

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= {i_file, i_page, i_slot};
        end
        r_key_q <= r_key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            r_next_mem[i_wr_addr] <= i_next;
        end
        r_next_q <= r_next_mem[i_rd_addr];
    end

    assign o_file = r_key_q[REC_W-1 -: FILE_W];
    assign o_page = r_key_q[SLOT_W +: PAGE_W];
    assign o_slot = r_key_q[SLOT_W-1:0];
    assign o_next = r_next_q;

endmodule

// ----- design/plh_free_list.sv -----
`timescale 1ns / 1ps

module plh_free_list import plh_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_alloc,
    input  logic                                               i_free,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   i_free_idx,
    output logic                                               o_avail,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   o_alloc_idx
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [EW-1:0] r_stack [ENTRIES];
    logic [EW-1:0] r_top;
    logic [CW-1:0] r_sp;
    logic [CW-1:0] r_hw;
    logic [CW-1:0] sp_m1;

    assign sp_m1       = r_sp - 1'b1;
    assign o_avail     = (r_sp != '0) || (r_hw != CW'(ENTRIES));
    assign o_alloc_idx = (r_sp != '0) ? r_top : r_hw[EW-1:0];

    // returned entries first, then untouched ones from the high-water mark upward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_hw <= '0;
        end else if (i_alloc) begin
            if (r_sp != '0) begin
                r_sp <= sp_m1;
            end else begin
                r_hw <= r_hw + 1'b1;
            end
        end else if (i_free) begin
            r_sp <= r_sp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_free) begin
            r_stack[r_sp[EW-1:0]] <= i_free_idx;
        end
        r_top <= r_stack[sp_m1[EW-1:0]];
    end

endmodule

// ----- design/page_lookup_hash_map.sv -----
`timescale 1ns / 1ps

// Chained hash map from a (file_number, page_number) key to a buffer slot. One operation
// (find, insert, delete) is in flight at a time and gives exactly one result beat. The
// entry memory is read once per chain entry visited, through its single registered read
// port; when BUCKETS is not a power of two the bucket index comes from a reciprocal
// multiplication and a correcting subtract, each registered. After reset the block
// sweeps the bucket head memory, clearing every head, before it takes the first beat. The
// input side may take a new beat while the previous result still waits in the output
// register.
module page_lookup_hash_map import plh_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state            r_state, n_state;
    t_in_beat          r_item;
    logic [BW-1:0]     r_clr, n_clr;
    logic [EW-1:0]     r_cur, n_cur;
    logic [EW-1:0]     r_prev, n_prev;
    logic              r_hp, n_hp;
    logic              r_hit, n_hit;
    t_status           r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic [EW:0]       r_bkt_mem [BUCKETS];
    logic [EW:0]       r_head;

    logic              bkt_we;
    logic [BW-1:0]     bkt_waddr;
    logic [EW:0]       bkt_wdata;

    logic [EW-1:0]     ent_rd_addr;
    logic [EW-1:0]     ent_wr_addr;
    logic              ent_key_we;
    logic              ent_next_we;
    logic [EW:0]       ent_next_wdata;
    logic [FILE_W-1:0] ent_file;
    logic [PAGE_W-1:0] ent_page;
    logic [SLOT_W-1:0] ent_slot;
    logic [EW:0]       ent_next;

    logic              fl_alloc;
    logic              fl_free;
    logic              fl_avail;
    logic [EW-1:0]     fl_idx;

    logic              hash_start;
    logic              hash_done;
    logic [BW-1:0]     bucket;
    logic              key_hit;
    logic              in_beat;

    assign in_beat = i_in_valid && o_in_ready;
    assign key_hit = (ent_file == r_item.file_number) && (ent_page == r_item.page_number);

    plh_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_file   (i_in_data.file_number),
        .i_page   (i_in_data.page_number),
        .o_done   (hash_done),
        .o_bucket (bucket)
    );

    plh_entry_mem #(.ENTRIES(ENTRIES)) u_entry_mem (
        .i_clk     (i_clk),
        .i_rd_addr (ent_rd_addr),
        .i_wr_addr (ent_wr_addr),
        .i_key_we  (ent_key_we),
        .i_file    (r_item.file_number),
        .i_page    (r_item.page_number),
        .i_slot    (r_item.buffer_slot),
        .i_next_we (ent_next_we),
        .i_next    (ent_next_wdata),
        .o_file    (ent_file),
        .o_page    (ent_page),
        .o_slot    (ent_slot),
        .o_next    (ent_next)
    );

    plh_free_list #(.ENTRIES(ENTRIES)) u_free_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alloc     (fl_alloc),
        .i_free      (fl_free),
        .i_free_idx  (r_cur),
        .o_avail     (fl_avail),
        .o_alloc_idx (fl_idx)
    );

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            r_bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        r_head <= r_bkt_mem[bucket];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == BW'(BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (hash_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = r_head[EW] ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                if (key_hit || !ent_next[EW]) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_clr          = r_clr;
        n_cur          = r_cur;
        n_prev         = r_prev;
        n_hp           = r_hp;
        n_hit          = r_hit;
        n_status       = r_status;
        n_slot         = r_slot;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_in_ready     = 1'b0;
        hash_start     = 1'b0;
        bkt_we         = 1'b0;
        bkt_waddr      = bucket;
        bkt_wdata      = ent_next;
        ent_rd_addr    = r_cur;
        ent_wr_addr    = fl_idx;
        ent_key_we     = 1'b0;
        ent_next_we    = 1'b0;
        ent_next_wdata = r_head;
        fl_alloc       = 1'b0;
        fl_free        = 1'b0;
        case (r_state)
            S_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                bkt_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                hash_start = i_in_valid;
            end
            S_HASH: begin
            end
            S_HEAD: begin
                n_cur       = r_head[EW-1:0];
                ent_rd_addr = r_head[EW-1:0];
                n_hp        = 1'b0;
                n_hit       = 1'b0;
            end
            S_WALK: begin
                if (key_hit) begin
                    n_hit = 1'b1;
                end else if (ent_next[EW]) begin
                    n_prev      = r_cur;
                    n_hp        = 1'b1;
                    n_cur       = ent_next[EW-1:0];
                    ent_rd_addr = ent_next[EW-1:0];
                end
            end
            S_FINISH: begin
                n_status = STAT_MISSING;
                n_slot   = '0;
                case (r_item.kind)
                    KIND_FIND: begin
                        if (r_hit) begin
                            n_status = STAT_OK;
                            n_slot   = ent_slot;
                        end
                    end
                    KIND_INSERT: begin
                        if (r_hit) begin
                            n_status = STAT_EXISTS;
                        end else if (fl_avail) begin
                            ent_key_we  = 1'b1;
                            ent_next_we = 1'b1;
                            bkt_we      = 1'b1;
                            bkt_wdata   = {1'b1, fl_idx};
                            fl_alloc    = 1'b1;
                            n_status    = STAT_OK;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_hit) begin
                            // unlink: predecessor or bucket head takes the successor
                            if (r_hp) begin
                                ent_wr_addr    = r_prev;
                                ent_next_we    = 1'b1;
                                ent_next_wdata = ent_next;
                            end else begin
                                bkt_we = 1'b1;
                            end
                            fl_free  = 1'b1;
                            n_status = STAT_OK;
                        end
                    end
                    default: begin
                        n_status = STAT_MISSING;
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.found_slot = r_slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_item <= i_in_data;
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_hp     <= n_hp;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("input taken while an operation is in flight");

    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESP))
        else $error("result beat raised outside the response state");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH || r_state == S_HEAD || r_state == S_WALK)
        |-> !(bkt_we || ent_key_we || ent_next_we))
        else $error("table written during a chain walk");

    a_slot_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STAT_OK) |-> o_out_data.found_slot == '0)
        else $error("slot reported on a failed operation");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_alloc |-> fl_avail)
        else $error("entry allocated from an empty pool");
`endif

endmodule

// ----- tb/page_lookup_hash_map_tb.sv -----
`timescale 1ns / 1ps

module page_lookup_hash_map_tb;
    import plh_pkg::*;

    localparam logic [1:0] KIND_BAD = 2'd3;
    localparam int KEY_COUNT = 96;
    localparam int HOT_COUNT = 6;
    localparam int SEG_COUNT = 8;
    localparam int SEG_LEN = 100;
    localparam int TAIL_CYCLES = 200;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    typedef struct {
        bit       drain_first;
        t_in_beat beat;
    } t_request;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    page_lookup_hash_map u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    bit [5:0]  head_idx [BUCKETS_DEF];
    bit        head_live [BUCKETS_DEF];
    bit [7:0]  ent_file [ENTRIES_DEF];
    bit [23:0] ent_page [ENTRIES_DEF];
    bit [5:0]  ent_buf [ENTRIES_DEF];
    bit [5:0]  ent_next [ENTRIES_DEF];
    bit        ent_next_live [ENTRIES_DEF];
    bit        ent_taken [ENTRIES_DEF];

    t_request  op_queue [$];
    t_out_beat pending_answers [$];
    t_in_beat  key_pool [KEY_COUNT];
    t_request  next_req;
    t_out_beat want;

    int err_count = 0;
    int ops_taken = 0;
    int results_seen = 0;
    int status_seen [4];
    int in_gap = 0;
    int out_stall = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_beat apply_op(input t_in_beat op);
        t_out_beat res;
        logic [SUM_W-1:0] sum;
        int bkt, cur, prev, at, steps, free_ix;
        bit live, hit, has_prev;
        res.status = STAT_MISSING;
        res.found_slot = '0;
        sum = SUM_W'(op.file_number) + SUM_W'(op.page_number);
        bkt = int'(sum % BUCKETS_DEF);
        live = head_live[bkt];
        cur = int'(head_idx[bkt]);
        prev = 0;
        at = 0;
        steps = 0;
        hit = 1'b0;
        has_prev = 1'b0;
        while (live && !hit && steps < ENTRIES_DEF) begin
            if (ent_file[cur] == op.file_number && ent_page[cur] == op.page_number) begin
                hit = 1'b1;
                at = cur;
            end else begin
                prev = cur;
                has_prev = 1'b1;
                live = ent_next_live[cur];
                cur = int'(ent_next[cur]);
                steps++;
            end
        end
        case (op.kind)
            KIND_FIND: begin
                if (hit) begin
                    res.status = STAT_OK;
                    res.found_slot = ent_buf[at];
                end
            end
            KIND_INSERT: begin
                if (hit) begin
                    res.status = STAT_EXISTS;
                end else begin
                    free_ix = 0;
                    while (free_ix < ENTRIES_DEF && ent_taken[free_ix])
                        free_ix++;
                    if (free_ix >= ENTRIES_DEF) begin
                        res.status = STAT_FULL;
                    end else begin
                        ent_taken[free_ix] = 1'b1;
                        ent_file[free_ix] = op.file_number;
                        ent_page[free_ix] = op.page_number;
                        ent_buf[free_ix] = op.buffer_slot;
                        ent_next[free_ix] = head_idx[bkt];
                        ent_next_live[free_ix] = head_live[bkt];
                        head_idx[bkt] = 6'(free_ix);
                        head_live[bkt] = 1'b1;
                        res.status = STAT_OK;
                    end
                end
            end
            KIND_DELETE: begin
                if (hit) begin
                    if (has_prev) begin
                        ent_next[prev] = ent_next[at];
                        ent_next_live[prev] = ent_next_live[at];
                    end else begin
                        head_idx[bkt] = ent_next[at];
                        head_live[bkt] = ent_next_live[at];
                    end
                    ent_taken[at] = 1'b0;
                    res.status = STAT_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_pause(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_op(input logic [1:0] kind, input logic [7:0] f,
                           input logic [23:0] p, input logic [5:0] slot,
                           input bit drain_first);
        t_request req;
        req.drain_first = drain_first;
        req.beat.kind = t_kind'(kind);
        req.beat.file_number = f;
        req.beat.page_number = p;
        req.beat.buffer_slot = slot;
        op_queue.push_back(req);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, exp_val);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_answers.push_back(apply_op(i_in_data));
                ops_taken++;
                if (ops_taken % 64 == 0)
                    in_steady = ($urandom_range(0, 3) == 0);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() > 0 &&
                             (!op_queue[0].drain_first || pending_answers.size() == 0)) begin
                    next_req = op_queue.pop_front();
                    i_in_data <= next_req.beat;
                    i_in_valid <= 1'b1;
                    in_gap = pick_pause(in_steady);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("status with nothing outstanding",
                                    int'(o_out_data.status), -1);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_out_data.status != want.status)
                        report_mismatch("status", int'(o_out_data.status),
                                        int'(want.status));
                    if (o_out_data.found_slot != want.found_slot)
                        report_mismatch("found_slot", int'(o_out_data.found_slot),
                                        int'(want.found_slot));
                    status_seen[want.status]++;
                end
                results_seen++;
                if (results_seen % 64 == 0)
                    out_steady = ($urandom_range(0, 3) == 0);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!out_steady && $urandom_range(0, 99) < 15)
                    out_stall = pick_pause(1'b0) + 1;
            end
        end
    end

    initial begin
        int hot [HOT_COUNT];
        int tgt, r, ins_pct, del_pct;
        t_phase phase;
        logic [1:0] kind;
        logic [7:0] f;
        logic [23:0] p;

        foreach (hot[i])
            hot[i] = $urandom_range(0, BUCKETS_DEF - 1);
        foreach (key_pool[i]) begin
            f = 8'($urandom_range(0, 255));
            p = 24'($urandom);
            if ($urandom_range(0, 99) < 70) begin
                tgt = hot[$urandom_range(0, HOT_COUNT - 1)];
                p[4:0] = 5'(tgt) - f[4:0];
            end
            key_pool[i] = '0;
            key_pool[i].file_number = f;
            key_pool[i].page_number = p;
        end

        // extremes, duplicate, unknown kind, head/middle/tail unlink in one chain
        push_op(KIND_FIND,   8'd0,   24'd0,        6'd0,  1'b0);
        push_op(KIND_DELETE, 8'd0,   24'd0,        6'd0,  1'b0);
        push_op(KIND_INSERT, 8'd0,   24'd0,        6'd0,  1'b0);
        push_op(KIND_INSERT, 8'd255, 24'hFFFFFF,   6'd63, 1'b0);
        push_op(KIND_FIND,   8'd0,   24'd0,        6'd21, 1'b0);
        push_op(KIND_FIND,   8'd255, 24'hFFFFFF,   6'd0,  1'b0);
        push_op(KIND_INSERT, 8'd0,   24'd0,        6'd5,  1'b0);
        push_op(KIND_BAD,    8'd255, 24'hFFFFFF,   6'd63, 1'b0);
        push_op(KIND_INSERT, 8'd254, 24'd0,        6'd11, 1'b0);
        push_op(KIND_INSERT, 8'd0,   24'd30,       6'd22, 1'b0);
        push_op(KIND_INSERT, 8'd1,   24'd29,       6'd42, 1'b0);
        push_op(KIND_DELETE, 8'd0,   24'd30,       6'd0,  1'b0);
        push_op(KIND_FIND,   8'd254, 24'd0,        6'd0,  1'b0);
        push_op(KIND_FIND,   8'd0,   24'd30,       6'd0,  1'b0);
        push_op(KIND_DELETE, 8'd1,   24'd29,       6'd0,  1'b0);
        push_op(KIND_FIND,   8'd255, 24'hFFFFFF,   6'd0,  1'b0);
        push_op(KIND_DELETE, 8'd255, 24'hFFFFFF,   6'd0,  1'b0);
        push_op(KIND_FIND,   8'd254, 24'd0,        6'd0,  1'b0);
        push_op(KIND_DELETE, 8'd0,   24'd0,        6'd0,  1'b0);
        push_op(KIND_DELETE, 8'd254, 24'd0,        6'd0,  1'b0);
        push_op(KIND_INSERT, 8'd128, 24'h800000,   6'd33, 1'b0);
        push_op(KIND_FIND,   8'd128, 24'h800000,   6'd63, 1'b0);
        push_op(KIND_DELETE, 8'd128, 24'h800000,   6'd0,  1'b0);

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg < 2)
                phase = PH_FILL;
            else if (seg == 2)
                phase = PH_DRAIN;
            else
                phase = t_phase'($urandom_range(0, 2));
            case (phase)
                PH_FILL:  begin ins_pct = 70; del_pct = 10; end
                PH_DRAIN: begin ins_pct = 15; del_pct = 55; end
                default:  begin ins_pct = 35; del_pct = 25; end
            endcase
            for (int n = 0; n < SEG_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    kind = KIND_INSERT;
                else if (r < ins_pct + del_pct)
                    kind = KIND_DELETE;
                else if (r < 96)
                    kind = KIND_FIND;
                else
                    kind = KIND_BAD;
                if ($urandom_range(0, 99) < 85) begin
                    tgt = $urandom_range(0, KEY_COUNT - 1);
                    f = key_pool[tgt].file_number;
                    p = key_pool[tgt].page_number;
                end else begin
                    f = 8'($urandom_range(0, 255));
                    p = 24'($urandom);
                end
                push_op(kind, f, p, 6'($urandom_range(0, 63)), n == 0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
        while (pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d operations through the map: %0d ok, %0d duplicate,",
                 ops_taken, status_seen[STAT_OK], status_seen[STAT_EXISTS]);
        $display("%0d pool full, %0d missing; chains built on %0d hot buckets, %0d mismatches",
                 status_seen[STAT_FULL], status_seen[STAT_MISSING], HOT_COUNT, err_count);
        if (err_count == 0 && pending_answers.size() == 0) begin
            $display("page_lookup_hash_map_tb passed");
        end else begin
            $display("page_lookup_hash_map_tb failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_answers.size());
        $display("page_lookup_hash_map_tb failed");
        $finish;
    end

endmodule
